// File: rtl/core/lfuc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfuc_pkg
// Shared widths and codes for the LFU cache table core.
// ----------------------------------------------------------------------------
package lfuc_pkg;

  localparam int unsigned CFG_W      = 5;
  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned VAL_PORT_W = 64;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned STAMP_W    = 32;

  localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Request kinds carried on in_tuser.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAMP_W-1:0] stamp_t;

endpackage

// File: rtl/core/lfu_cache_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Key-value table with least-frequently-used replacement and oldest-count
// tie break, scanned one entry per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one request per handshake. in_tuser carries the
//   kind (get or set), in_tdata the key and the value to store.
//   Result channel (out_*): exactly one result per request, in order.
//   out_tuser flags a hit and an eviction, out_tdata carries the value read
//   on a get hit and the key of the evicted entry.
//   Configuration: cfg_wr_en writes cfg_wr_data into the capacity register;
//   write it only while no request is in flight.
//   Timing: a request is scanned against the table one entry per cycle
//   through a single read port on the table memories and one shared
//   match/victim compare unit. The result is registered when the finished
//   scan commits; in_tready rises with it, so a new request is accepted
//   only after the previous one has committed.
//   Stalls: the result sits in an output register, so a new request is
//   taken while it waits. A finished scan holds its table update until the
//   output register is free.
//   Reset (rst_n low, synchronous): all entries become invalid, the use
//   clock returns to zero and the capacity register to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table_core
  import lfuc_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,  // capacity_in_use
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [127:0]     in_tdata,     // lookup_key [63:0], write_value [127:64]
  input  logic [0:0]       in_tuser,     // action [0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [127:0]     out_tdata,    // read_value [63:0], evicted_key [127:64]
  output logic [1:0]       out_tuser     // found [0], evicted [1]
);

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  // Table memories.
  logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem   [CAPACITY];
  count_t                cnt_mem   [CAPACITY];
  stamp_t                stamp_mem [CAPACITY];

  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  count_t                rd_cnt_r;
  stamp_t                rd_stamp_r;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      cap_r, cap_nxt;
  logic [CAPACITY-1:0]   valid_r, valid_nxt;
  stamp_t                clk_stamp_r, clk_stamp_nxt;

  logic                  req_set_r, req_set_nxt;
  logic [KEY_BITS-1:0]   req_key_r, req_key_nxt;
  logic [VALUE_BITS-1:0] req_val_r, req_val_nxt;

  logic [IDX_W-1:0]      issue_idx_r, issue_idx_nxt;
  logic                  issue_done_r, issue_done_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;

  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [VALUE_BITS-1:0] hit_val_r, hit_val_nxt;
  count_t                hit_cnt_r, hit_cnt_nxt;
  logic                  free_r, free_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic                  vic_r, vic_nxt;
  logic [IDX_W-1:0]      vic_idx_r, vic_idx_nxt;
  logic [KEY_BITS-1:0]   vic_key_r, vic_key_nxt;
  count_t                best_cnt_r, best_cnt_nxt;
  stamp_t                best_age_r, best_age_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_evict_r, out_evict_nxt;
  logic [VAL_PORT_W-1:0] out_val_r, out_val_nxt;
  logic [KEY_PORT_W-1:0] out_key_r, out_key_nxt;

  // Shared compare unit and table write port.
  stamp_t                age;
  logic                  key_match, vic_better;
  logic [CMP_W-1:0]      cap_ext, eff_cap;
  logic                  commit, evict;
  logic                  wr_key_en, wr_val_en, wr_cnt_en, wr_stamp_en;
  logic [IDX_W-1:0]      wr_idx;
  count_t                wr_cnt;
  stamp_t                wr_stamp;

  assign age        = clk_stamp_r - rd_stamp_r;
  assign key_match  = (rd_key_r == req_key_r);
  assign vic_better = !vic_r || (rd_cnt_r < best_cnt_r) ||
                      ((rd_cnt_r == best_cnt_r) && (age > best_age_r));

  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      eff_cap = CMP_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign commit = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign evict  = (CMP_W'(fill_r) >= eff_cap) || !free_r;

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cfg_wr_en ? cfg_wr_data : cap_r;
    valid_nxt      = valid_r;
    clk_stamp_nxt  = clk_stamp_r;
    req_set_nxt    = req_set_r;
    req_key_nxt    = req_key_r;
    req_val_nxt    = req_val_r;
    issue_idx_nxt  = issue_idx_r;
    issue_done_nxt = issue_done_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = issue_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_val_nxt    = hit_val_r;
    hit_cnt_nxt    = hit_cnt_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    vic_nxt        = vic_r;
    vic_idx_nxt    = vic_idx_r;
    vic_key_nxt    = vic_key_r;
    best_cnt_nxt   = best_cnt_r;
    best_age_nxt   = best_age_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_evict_nxt  = out_evict_r;
    out_val_nxt    = out_val_r;
    out_key_nxt    = out_key_r;
    wr_key_en      = 1'b0;
    wr_val_en      = 1'b0;
    wr_cnt_en      = 1'b0;
    wr_stamp_en    = 1'b0;
    wr_idx         = hit_idx_r;
    wr_cnt         = hit_cnt_r + count_t'(1);
    wr_stamp       = clk_stamp_r + stamp_t'(1);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt      = ST_SCAN;
          req_set_nxt    = in_tuser[0];
          req_key_nxt    = in_tdata[KEY_BITS-1:0];
          req_val_nxt    = in_tdata[KEY_PORT_W +: VALUE_BITS];
          issue_idx_nxt  = '0;
          issue_done_nxt = 1'b0;
          hit_nxt        = 1'b0;
          free_nxt       = 1'b0;
          vic_nxt        = 1'b0;
          fill_nxt       = '0;
        end
      end
      ST_SCAN: begin
        if (!issue_done_r) begin
          rd_vld_nxt = 1'b1;
          if (issue_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            issue_idx_nxt = issue_idx_r + IDX_W'(1);
          end
        end
        if (rd_vld_r) begin
          if (valid_r[rd_idx_r]) begin
            fill_nxt = fill_r + FILL_W'(1);
            if (!hit_r && key_match) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = rd_idx_r;
              hit_val_nxt = rd_val_r;
              hit_cnt_nxt = rd_cnt_r;
            end
            if (vic_better) begin
              vic_nxt      = 1'b1;
              vic_idx_nxt  = rd_idx_r;
              vic_key_nxt  = rd_key_r;
              best_cnt_nxt = rd_cnt_r;
              best_age_nxt = age;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
          if (rd_idx_r == LAST_IDX) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_evict_nxt = 1'b0;
          out_val_nxt   = '0;
          out_key_nxt   = '0;
          if (hit_r) begin
            wr_idx    = hit_idx_r;
            wr_val_en = req_set_r;
            if (req_set_r == ACT_GET) begin
              out_val_nxt = VAL_PORT_W'(hit_val_r);
            end
            // A saturated count keeps its stamp and does not advance the clock.
            if (hit_cnt_r != COUNT_MAX) begin
              wr_cnt_en     = 1'b1;
              wr_stamp_en   = 1'b1;
              clk_stamp_nxt = wr_stamp;
            end
          end else if (req_set_r == ACT_SET) begin
            wr_idx        = evict ? vic_idx_r : free_idx_r;
            wr_key_en     = 1'b1;
            wr_val_en     = 1'b1;
            wr_cnt_en     = 1'b1;
            wr_stamp_en   = 1'b1;
            wr_cnt        = count_t'(1);
            clk_stamp_nxt = wr_stamp;
            valid_nxt[wr_idx] = 1'b1;
            if (evict) begin
              out_evict_nxt = 1'b1;
              out_key_nxt   = KEY_PORT_W'(vic_key_r);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= CAP_RESET;
      valid_r      <= '0;
      clk_stamp_r  <= '0;
      issue_done_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      valid_r      <= valid_nxt;
      clk_stamp_r  <= clk_stamp_nxt;
      issue_done_r <= issue_done_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_set_r   <= req_set_nxt;
    req_key_r   <= req_key_nxt;
    req_val_r   <= req_val_nxt;
    issue_idx_r <= issue_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_val_r   <= hit_val_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    vic_r       <= vic_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_key_r   <= vic_key_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_age_r  <= best_age_nxt;
    fill_r      <= fill_nxt;
    out_found_r <= out_found_nxt;
    out_evict_r <= out_evict_nxt;
    out_val_r   <= out_val_nxt;
    out_key_r   <= out_key_nxt;
  end

  // One read port scanning the table, one write port for the update.
  always_ff @(posedge clk) begin
    rd_key_r   <= key_mem[issue_idx_r];
    rd_val_r   <= val_mem[issue_idx_r];
    rd_cnt_r   <= cnt_mem[issue_idx_r];
    rd_stamp_r <= stamp_mem[issue_idx_r];
    if (wr_key_en) begin
      key_mem[wr_idx] <= req_key_r;
    end
    if (wr_val_en) begin
      val_mem[wr_idx] <= req_val_r;
    end
    if (wr_cnt_en) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (wr_stamp_en) begin
      stamp_mem[wr_idx] <= wr_stamp;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_key_r, out_val_r};
  assign out_tuser  = {out_evict_r, out_found_r};

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evict_r |-> !out_found_r)
    else $error("eviction reported together with a hit");

  a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(valid_r) >= $past($countones(valid_r)))
    else $error("valid entry count decreased");

  a_evict_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    commit && !hit_r && req_set_r && evict |=>
      $countones(valid_r) == $past($countones(valid_r)))
    else $error("eviction changed the number of valid entries");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (clk_stamp_r == $past(clk_stamp_r)) ||
             (clk_stamp_r == $past(clk_stamp_r) + stamp_t'(1)))
    else $error("use clock advanced by more than one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new request accepted during a scan");

endmodule
